>>> rtl/core/lpjm_pkg.sv
`default_nettype none
package lpjm_pkg;

  localparam logic [19:0] NOMINAL_RESET = 20'd1000;
  localparam logic [31:0] DISCARD_RESET = 32'd100000;
  localparam logic [15:0] WINDOW_RESET  = 16'd1024;
  localparam int          CFG_W         = 32;
  localparam int          DIV_W         = 64;

  // register indexes
  localparam logic [1:0] REG_NOMINAL = 2'd0;
  localparam logic [1:0] REG_DISCARD = 2'd1;
  localparam logic [1:0] REG_WINDOW  = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_END   = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [63:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_cycles;
    logic [31:0] jitter_low;
    logic [31:0] jitter_mean;
    logic [31:0] jitter_high;
    logic [31:0] exec_low;
    logic [31:0] exec_mean;
    logic [31:0] exec_high;
    logic [31:0] slip_count;
    logic [31:0] missed_total;
    logic [31:0] slip_peak;
  } out_item_t;

  // divider request and status
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/lpjm_divider.sv
`default_nettype none
module lpjm_divider
  import lpjm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   shifted;

  // one restoring step per cycle while busy
  assign shifted = {rem, quo[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!trial[DIV_W]) begin
          rem <= trial[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo};

endmodule
`default_nettype wire

>>> rtl/core/loop_period_jitter_monitor.sv
`default_nettype none
// Loop period jitter monitor.
// Input channel (in_valid/in_ready/in_data) carries start and end events with
// a microsecond timestamp. Output channel (out_valid/out_ready/out_data)
// carries one statistics report per window of window_length end events.
// Config port (cfg_we/cfg_index/cfg_data) writes nominal_period,
// discard_limit and window_length; write only while idle.
// Arithmetic: one shared 64-bit restoring divider, one bit per cycle.
// A start with a jitter gap or an ignored gap uses no divide; a start with a
// slip gap runs the missed-period divide. An end that closes no window uses
// no divide; an end that closes one runs the jitter mean divide (only if a
// jitter sample was counted) and then the exec mean divide for the report.
// in_ready is low while an item is in work or a report waits.
// A stalled receiver holds the report in the output register; no new item
// is taken until it leaves. Reset (rst, synchronous) restores register
// defaults and clears all statistics; no clearing pass is needed.
module loop_period_jitter_monitor
  import lpjm_pkg::*;
#(
  parameter logic [19:0] NOMINAL_DEF = NOMINAL_RESET,
  parameter logic [31:0] DISCARD_DEF = DISCARD_RESET,
  parameter logic [15:0] WINDOW_DEF  = WINDOW_RESET
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_SLIP = 3'd2;
  localparam logic [2:0] S_JDIV = 3'd3;
  localparam logic [2:0] S_EDIV = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [19:0] nominal;
  logic [31:0] discard;
  logic [15:0] window;

  logic [63:0] start_time, previous_start, jitter_total, exec_total;
  logic [31:0] cycle_total, jitter_minimum, jitter_maximum, jitter_count;
  logic [31:0] slip_tally, missed_tally, slip_largest;
  logic [31:0] exec_minimum, exec_maximum, exec_count;

  in_item_t    item;
  logic [63:0] gap;
  logic [31:0] excess;

  div_req_t dreq;
  div_rsp_t drsp;

  logic started;
  logic [2:0] state_next;

  lpjm_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // effective config
  logic [63:0] nom64;
  logic [31:0] win32;
  assign nom64 = (nominal == '0) ? 64'd1 : {44'd0, nominal};
  assign win32 = (window == '0) ? 32'd1 : {16'd0, window};

  // per-event arithmetic
  logic [63:0] gap_c, d_c, jit64, jsum;
  logic [31:0] jit, ex;
  logic [64:0] jsum_w;
  assign gap_c  = (item.timestamp >= previous_start) ?
                  item.timestamp - previous_start : 64'd0;
  assign d_c    = (item.timestamp >= start_time) ? item.timestamp - start_time : 64'd0;
  assign ex     = (d_c[63:32] != '0) ? 32'hFFFF_FFFF : d_c[31:0];
  assign jit64  = (gap_c > nom64) ? gap_c - nom64 : nom64 - gap_c;
  assign jit    = jit64[31:0];
  assign jsum_w = {1'b0, jitter_total} + {33'd0, jit};
  assign jsum   = jsum_w[64] ? 64'hFFFF_FFFF_FFFF_FFFF : jsum_w[63:0];

  assign in_ready = (state == S_IDLE);

  // divider operands and launch
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = gap;
    dreq.divisor  = nom64;
    if (!started) begin
      if (state == S_SLIP) dreq.start = 1'b1;
      if (state == S_JDIV && jitter_count != '0) dreq.start = 1'b1;
      if (state == S_EDIV) dreq.start = 1'b1;
    end
    if (state == S_JDIV) begin
      dreq.dividend = jitter_total;
      dreq.divisor  = {32'd0, jitter_count};
    end else if (state == S_EDIV) begin
      dreq.dividend = exec_total;
      dreq.divisor  = {32'd0, exec_count};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      nominal        <= NOMINAL_DEF;
      discard        <= DISCARD_DEF;
      window         <= WINDOW_DEF;
      out_valid      <= 1'b0;
      started        <= 1'b0;
      start_time     <= '0;
      previous_start <= '0;
      cycle_total    <= '0;
      jitter_minimum <= '1;
      jitter_maximum <= '0;
      jitter_total   <= '0;
      jitter_count   <= '0;
      slip_tally     <= '0;
      missed_tally   <= '0;
      slip_largest   <= '0;
      exec_minimum   <= '1;
      exec_maximum   <= '0;
      exec_total     <= '0;
      exec_count     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NOMINAL: nominal <= cfg_data[19:0];
          REG_DISCARD: discard <= cfg_data[31:0];
          REG_WINDOW:  window  <= cfg_data[15:0];
          default: ;
        endcase
      end
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_valid) item <= in_data;
        end
        S_EVAL: begin
          if (item.opcode == OP_START) begin
            start_time     <= item.timestamp;
            previous_start <= item.timestamp;
            gap            <= gap_c;
            if (previous_start != '0 && gap_c < {32'd0, discard}) begin
              if (gap_c < (nom64 << 1)) begin
                if (jit64[31:0] < jitter_minimum) jitter_minimum <= jit64[31:0];
                if (jit64[31:0] > jitter_maximum) jitter_maximum <= jit64[31:0];
                jitter_count <= jitter_count + 1'b1;
              end
            end
          end else begin
            if (ex < exec_minimum) exec_minimum <= ex;
            if (ex > exec_maximum) exec_maximum <= ex;
            exec_total  <= exec_total + {32'd0, ex};
            exec_count  <= exec_count + 1'b1;
            cycle_total <= cycle_total + 1'b1;
          end
        end
        S_SLIP: begin
          if (drsp.done) begin
            missed_tally <= missed_tally + drsp.quotient[31:0] - 32'd1;
            slip_tally   <= slip_tally + 1'b1;
            if (excess > slip_largest) slip_largest <= excess;
          end
        end
        S_JDIV: begin
          if (!started && jitter_count == '0) begin
            out_data.jitter_low  <= '0;
            out_data.jitter_mean <= '0;
            out_data.jitter_high <= '0;
          end else if (drsp.done) begin
            out_data.jitter_low  <= jitter_minimum;
            out_data.jitter_high <= jitter_maximum;
            out_data.jitter_mean <= (drsp.quotient[63:32] != '0) ?
                                    32'hFFFF_FFFF : drsp.quotient[31:0];
          end
        end
        S_EDIV: begin
          if (drsp.done) begin
            out_data.total_cycles <= cycle_total;
            out_data.exec_low     <= exec_minimum;
            out_data.exec_mean    <= drsp.quotient[31:0];
            out_data.exec_high    <= exec_maximum;
            out_data.slip_count   <= slip_tally;
            out_data.missed_total <= missed_tally;
            out_data.slip_peak    <= slip_largest;
            out_valid             <= 1'b1;
            jitter_minimum <= '1;
            jitter_maximum <= '0;
            jitter_total   <= '0;
            jitter_count   <= '0;
            slip_tally     <= '0;
            missed_tally   <= '0;
            slip_largest   <= '0;
            exec_minimum   <= '1;
            exec_maximum   <= '0;
            exec_total     <= '0;
            exec_count     <= '0;
          end
        end
        S_OUT: begin
          if (out_ready) out_valid <= 1'b0;
        end
        default: ;
      endcase
      // jitter sum update kept apart from the compare block
      if (state == S_EVAL && item.opcode == OP_START && previous_start != '0 &&
          gap_c < {32'd0, discard} && gap_c < (nom64 << 1)) begin
        jitter_total <= jsum;
      end
      started <= dreq.start ? 1'b1 : (drsp.done ? 1'b0 : started);
    end
  end

  // excess is the slip gap minus nominal, truncated
  always_ff @(posedge clk) begin
    if (state == S_EVAL) excess <= gap_c[31:0] - nom64[31:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EVAL;
      S_EVAL: begin
        if (item.opcode == OP_START) begin
          if (previous_start != '0 && gap_c < {32'd0, discard} &&
              !(gap_c < (nom64 << 1))) state_next = S_SLIP;
          else state_next = S_IDLE;
        end else if (exec_count + 32'd1 >= win32) begin
          state_next = S_JDIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SLIP: if (drsp.done) state_next = S_IDLE;
      S_JDIV: begin
        if (!started && jitter_count == '0) state_next = S_EDIV;
        else if (drsp.done) state_next = S_EDIV;
      end
      S_EDIV: if (drsp.done) state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  // no new item while a report is pending
  a_no_accept_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("item accepted with report pending");
  // report appears only after the exec mean divide
  a_out_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EDIV) else $error("report out of order");
  // window statistics clear on report
  a_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> exec_count == '0) else $error("window not cleared");
`endif

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lpjm_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_NOMINAL;
  logic [CFG_W-1:0] cfg_data = '0;

  loop_period_jitter_monitor DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor copy of registers and window statistics
  logic [19:0] nom_reg;
  logic [31:0] disc_reg;
  logic [15:0] win_reg;
  logic [63:0] t_start, t_prev;
  logic [31:0] cyc_total, jit_min, jit_max, jit_cnt, slips, missed, slip_top;
  logic [63:0] jit_sum, ex_sum;
  logic [31:0] ex_min, ex_max, ex_cnt;

  out_item_t reports_due[$];
  int        errors = 0;
  int        send_idle = 0;
  int        recv_stall = 0;
  int        quiet_cycles = 0;

  function automatic logic [63:0] lcg64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic clear_window();
    jit_min = '1; jit_max = 0; jit_sum = 0; jit_cnt = 0;
    slips = 0; missed = 0; slip_top = 0;
    ex_min = '1; ex_max = 0; ex_sum = 0; ex_cnt = 0;
  endtask

  task automatic model_reset();
    nom_reg = NOMINAL_RESET; disc_reg = DISCARD_RESET; win_reg = WINDOW_RESET;
    t_start = 0; t_prev = 0; cyc_total = 0;
    clear_window();
  endtask

  // update the predicted state for one event, queue a report if the window closes
  task automatic predict_event(in_item_t it);
    logic [63:0] nom, gap, d, m;
    logic [31:0] jit, ex, win;
    out_item_t   rep;
    if (it.opcode == OP_START) begin
      t_start = it.timestamp;
      if (t_prev != 0) begin
        nom = (nom_reg == 0) ? 64'd1 : 64'(nom_reg);
        gap = (it.timestamp >= t_prev) ? it.timestamp - t_prev : 64'd0;
        if (gap < 64'(disc_reg)) begin
          if (gap < 2 * nom) begin
            jit = 32'((gap > nom) ? gap - nom : nom - gap);
            if (jit < jit_min) jit_min = jit;
            if (jit > jit_max) jit_max = jit;
            if (jit_sum > 64'hFFFF_FFFF_FFFF_FFFF - 64'(jit)) jit_sum = '1;
            else jit_sum = jit_sum + 64'(jit);
            jit_cnt++;
          end else begin
            if (32'(gap - nom) > slip_top) slip_top = 32'(gap - nom);
            slips++;
            missed = missed + 32'(gap / nom - 1);
          end
        end
      end
      t_prev = it.timestamp;
    end else begin
      d = (it.timestamp >= t_start) ? it.timestamp - t_start : 64'd0;
      ex = (d > 64'hFFFF_FFFF) ? '1 : d[31:0];
      win = (win_reg == 0) ? 32'd1 : 32'(win_reg);
      if (ex < ex_min) ex_min = ex;
      if (ex > ex_max) ex_max = ex;
      ex_sum = ex_sum + 64'(ex);
      ex_cnt++;
      cyc_total++;
      if (ex_cnt >= win) begin
        rep.total_cycles = cyc_total;
        if (jit_cnt != 0) begin
          m = jit_sum / 64'(jit_cnt);
          rep.jitter_low = jit_min;
          rep.jitter_mean = (m > 64'hFFFF_FFFF) ? '1 : m[31:0];
          rep.jitter_high = jit_max;
        end else begin
          rep.jitter_low = 0; rep.jitter_mean = 0; rep.jitter_high = 0;
        end
        rep.exec_low = ex_min;
        m = ex_sum / 64'(ex_cnt);
        rep.exec_mean = m[31:0];
        rep.exec_high = ex_max;
        rep.slip_count = slips;
        rep.missed_total = missed;
        rep.slip_peak = slip_top;
        reports_due.push_back(rep);
        clear_window();
      end
    end
  endtask

  // send one event, with random idle cycles before it
  task automatic send_event(logic op, logic [63:0] ts);
    in_item_t it;
    it.opcode = op; it.timestamp = ts;
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_event(it);
    in_valid <= 1'b0;
    // the block drops in_ready after an accept
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (reports_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NOMINAL) nom_reg = val[19:0];
    else if (idx == REG_DISCARD) disc_reg = val;
    else if (idx == REG_WINDOW) win_reg = val[15:0];
    @(posedge clk);
  endtask

  // receiver stall and report check
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
    if (!rst && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        $display("%0t unexpected report: actual %p", $time, out_data);
        errors++;
      end else begin
        out_item_t e;
        e = reports_due.pop_front();
        if (out_data.total_cycles !== e.total_cycles) begin
          $display("%0t total_cycles exp %0d act %0d", $time, e.total_cycles,
                   out_data.total_cycles); errors++;
        end
        if (out_data.jitter_low !== e.jitter_low) begin
          $display("%0t jitter_low exp %0d act %0d", $time, e.jitter_low,
                   out_data.jitter_low); errors++;
        end
        if (out_data.jitter_mean !== e.jitter_mean) begin
          $display("%0t jitter_mean exp %0d act %0d", $time, e.jitter_mean,
                   out_data.jitter_mean); errors++;
        end
        if (out_data.jitter_high !== e.jitter_high) begin
          $display("%0t jitter_high exp %0d act %0d", $time, e.jitter_high,
                   out_data.jitter_high); errors++;
        end
        if (out_data.exec_low !== e.exec_low) begin
          $display("%0t exec_low exp %0d act %0d", $time, e.exec_low,
                   out_data.exec_low); errors++;
        end
        if (out_data.exec_mean !== e.exec_mean) begin
          $display("%0t exec_mean exp %0d act %0d", $time, e.exec_mean,
                   out_data.exec_mean); errors++;
        end
        if (out_data.exec_high !== e.exec_high) begin
          $display("%0t exec_high exp %0d act %0d", $time, e.exec_high,
                   out_data.exec_high); errors++;
        end
        if (out_data.slip_count !== e.slip_count) begin
          $display("%0t slip_count exp %0d act %0d", $time, e.slip_count,
                   out_data.slip_count); errors++;
        end
        if (out_data.missed_total !== e.missed_total) begin
          $display("%0t missed_total exp %0d act %0d", $time, e.missed_total,
                   out_data.missed_total); errors++;
        end
        if (out_data.slip_peak !== e.slip_peak) begin
          $display("%0t slip_peak exp %0d act %0d", $time, e.slip_peak,
                   out_data.slip_peak); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  // extremes, special cases, saturation, backwards time
  task automatic test_directed();
    write_reg(REG_WINDOW, 32'd4);
    send_event(OP_END, 64'd5);
    send_event(OP_START, 64'd0);
    send_event(OP_START, 64'd1000);
    send_event(OP_END, 64'd1100);
    send_event(OP_START, 64'd2003);
    send_event(OP_START, 64'd2990);
    send_event(OP_START, 64'd7000);
    send_event(OP_START, 64'd6000);
    send_event(OP_END, 64'd100);
    send_event(OP_END, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(OP_START, 64'hFFFF_FFFF_FFFF_F000);
    send_event(OP_START, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(OP_START, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(OP_END, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_drained();
    write_reg(REG_NOMINAL, 32'd0);
    write_reg(REG_WINDOW, 32'hFFFF_0000);
    write_reg(REG_DISCARD, 32'hFFFF_FFFF);
    send_event(OP_START, 64'd10);
    send_event(OP_START, 64'd11);
    send_event(OP_START, 64'd10000000);
    send_event(OP_END, 64'd10000050);
    wait_drained();
    write_reg(REG_NOMINAL, 32'hFFFF_FFFF);
    write_reg(REG_DISCARD, 32'd1);
    send_event(OP_START, 64'd3000000);
    send_event(OP_END, 64'd3000001);
    wait_drained();
  endtask

  // well-formed loops with random jitter, slips and noise
  task automatic test_random(int n, int idle_s, int idle_r);
    logic [63:0] now;
    int k;
    send_idle = idle_s; recv_stall = idle_r;
    now = lcg64() >> $urandom_range(63, 1);
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0: begin
          send_event($urandom_range(1), lcg64());
          k++;
        end
        1: begin
          now = now + 64'(nom_reg) * $urandom_range(8, 2) + $urandom_range(50);
          send_event(OP_START, now);
          send_event(OP_END, now + $urandom_range(2000));
          k += 2;
        end
        default: begin
          now = now + 64'(nom_reg) + $urandom_range(2 * 40) - 40;
          send_event(OP_START, now);
          send_event(OP_END, now + $urandom_range(nom_reg));
          k += 2;
        end
      endcase
    end
    wait_drained();
    send_idle = 0; recv_stall = 0;
  endtask

  task automatic test_settings();
    write_reg(REG_NOMINAL, 32'd1000);
    write_reg(REG_DISCARD, 32'd100000);
    write_reg(REG_WINDOW, 32'd3);
    test_random(250, 0, 0);
    write_reg(REG_WINDOW, 32'd1);
    write_reg(REG_NOMINAL, 32'd1);
    test_random(250, 56, 0);
    write_reg(REG_NOMINAL, 32'hFFFFF);
    write_reg(REG_DISCARD, 32'd5000000);
    write_reg(REG_WINDOW, 32'd5);
    test_random(250, 0, 56);
    write_reg(REG_NOMINAL, 32'd200);
    write_reg(REG_DISCARD, 32'd900);
    write_reg(REG_WINDOW, 32'd2);
    test_random(250, 33, 33);
    // window raised, then lowered below the running count
    write_reg(REG_WINDOW, 32'd40);
    test_random(60, 0, 0);
    write_reg(REG_WINDOW, 32'd1);
    test_random(90, 0, 0);
    write_reg(REG_WINDOW, 32'hFFFF);
    test_random(20, 0, 0);
  endtask

  initial begin
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    wait_drained();
    if (errors == 0 && reports_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> loop_period_jitter_monitor.f
rtl/core/lpjm_pkg.sv
rtl/core/lpjm_divider.sv
rtl/core/loop_period_jitter_monitor.sv
bench/tb_top.sv
